// File: hw/rtl/scaled_multiply_divide_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef SCALED_MULTIPLY_DIVIDE_UNIT_ASSERT_SVH
`define SCALED_MULTIPLY_DIVIDE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scaled_multiply_divide_unit: port check failed");

// Consequent must hold in the cycle after the antecedent.
`define SMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scaled_multiply_divide_unit: port check failed");

`endif

// File: hw/rtl/smd_pkg.sv
package smd_pkg;

    localparam int unsigned DW         = 32;
    localparam int unsigned SHW        = 5;
    localparam int unsigned SCAN_STEPS = 5;
    localparam int unsigned DIV_STEPS  = 32;
    localparam int unsigned DCW        = $clog2(DIV_STEPS);
    localparam int unsigned SCW        = $clog2(SCAN_STEPS);

    localparam logic [DW-1:0] SAT_MAG = 32'h7FFF_FFFF;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_PREP,
        ST_DIV,
        ST_MUL2,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic          load;
        logic [DW:0]   op_x;
        logic [DW:0]   op_y;
    } mul_req_t;

    typedef struct packed
    {
        logic          start;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } div_req_t;

    typedef struct packed
    {
        logic          done;
        logic [DW-1:0] quo;
    } div_rsp_t;

    typedef struct packed
    {
        logic          start;
        logic [DW-1:0] hi_mag;
        logic [DW-1:0] lo_mag;
        logic [DW-1:0] limit;
    } scan_req_t;

    typedef struct packed
    {
        logic           done;
        logic [SHW-1:0] lz;
        logic [SHW-1:0] right;
    } scan_rsp_t;

    function automatic logic [DW-1:0] mag32(logic [DW-1:0] v);
        return v[DW-1] ? (DW'(0) - v) : v;
    endfunction

    function automatic logic [DW-1:0] apply_sign(logic [DW-1:0] m, logic neg);
        return neg ? (DW'(0) - m) : m;
    endfunction

endpackage

// File: hw/rtl/smd_mul.sv
module smd_mul
(
    input  logic                       clk,
    input  smd_pkg::mul_req_t          req,
    output logic [2*smd_pkg::DW-1:0]   prod
);
    import smd_pkg::*;

    logic signed [2*DW+1:0] full;
    logic [2*DW-1:0]        prod_reg;
    logic [2*DW-1:0]        prod_next;

    assign full      = $signed(req.op_x) * $signed(req.op_y);
    assign prod_next = full[2*DW-1:0];
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// File: hw/rtl/smd_scan.sv
module smd_scan
(
    input  logic                clk,
    input  logic                rst_n,
    input  smd_pkg::scan_req_t  req,
    output smd_pkg::scan_rsp_t  rsp
);
    import smd_pkg::*;

    logic           busy_reg, busy_next;
    logic [SCW-1:0] step_reg, step_next;
    logic [DW-1:0]  x_reg, x_next;
    logic [DW-1:0]  lo_reg, lo_next;
    logic [DW-1:0]  lim_reg, lim_next;
    logic [SHW-1:0] lz_reg, lz_next;
    logic [SHW-1:0] r_reg, r_next;

    logic [SHW-1:0] k;
    logic [SHW-1:0] probe;
    logic [DW-1:0]  mask;
    logic           last;

    // step size halves each cycle: 16, 8, 4, 2, 1
    assign k     = SHW'(1 << (SCAN_STEPS - 1)) >> step_reg;
    assign probe = r_reg + k - SHW'(1);
    assign mask  = ~({DW{1'b1}} >> k);
    assign last  = (step_reg == SCW'(SCAN_STEPS - 1));

    assign rsp.done  = busy_reg && last;
    assign rsp.lz    = lz_reg;
    assign rsp.right = r_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        x_next    = x_reg;
        lo_next   = lo_reg;
        lim_next  = lim_reg;
        lz_next   = lz_reg;
        r_next    = r_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            x_next    = req.hi_mag;
            lo_next   = req.lo_mag;
            lim_next  = req.limit;
            lz_next   = '0;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            // normalize: drop k leading zeros when they are all clear
            if ((x_reg & mask) == '0)
            begin
                x_next  = x_reg << k;
                lz_next = lz_reg + k;
            end
            // advance past shifts that still leave the value above the limit
            if ((lo_reg >> probe) > lim_reg)
            begin
                r_next = r_reg + k;
            end
            step_next = step_reg + SCW'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        lo_reg  <= lo_next;
        lim_reg <= lim_next;
        lz_reg  <= lz_next;
        r_reg   <= r_next;
    end

endmodule

// File: hw/rtl/smd_div.sv
module smd_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  smd_pkg::div_req_t  req,
    output smd_pkg::div_rsp_t  rsp
);
    import smd_pkg::*;

    logic           busy_reg, busy_next;
    logic [DCW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [DW-1:0]  dsr_reg, dsr_next;

    logic [DW:0]    rem_sh;
    logic [DW+1:0]  diff;
    logic           last;

    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
    assign last   = (cnt_reg == DCW'(DIV_STEPS - 1));

    assign rsp.done = busy_reg && last;
    assign rsp.quo  = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // restoring step: keep the difference only when no borrow
            if (!diff[DW+1])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DCW'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

// File: hw/rtl/scaled_multiply_divide_unit.sv
// Channel   Handshake       Payload
// ------    ------------    -----------------------------------
// item in   start / busy    factor_a, factor_b, divisor (s32)
// result    done (strobe)   quotient (s32)
//
// An item is taken when start is high and busy is low. done marks quotient for one
// cycle. A zero multiplicand or an immediate saturation goes from check to done; a
// saturating shift search runs the 5-step search and prep, the exact-product path
// the 32-step divider and finish, the scaled path search, prep, divider, a second
// multiply and finish. A new item may be taken in the cycle done is high. rst_n
// clears the sequencer asynchronously; the receiver cannot stall the result.
module scaled_multiply_divide_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [smd_pkg::DW-1:0]    factor_a,
    input  logic [smd_pkg::DW-1:0]    factor_b,
    input  logic [smd_pkg::DW-1:0]    divisor,
    output logic                      done,
    output logic [smd_pkg::DW-1:0]    quotient
);
    import smd_pkg::*;

    state_t         state_reg, state_next;
    logic [DW-1:0]  a_reg, a_next;
    logic [DW-1:0]  b_reg, b_next;
    logic [DW-1:0]  c_reg, c_next;
    logic [DW-1:0]  hi_reg, hi_next;
    logic [DW-1:0]  lo_reg, lo_next;
    logic [SHW-1:0] shift_reg, shift_next;
    logic           neg_reg, neg_next;
    logic           fast_reg, fast_next;
    logic [DW-1:0]  res_reg, res_next;

    mul_req_t        mul_req;
    logic [2*DW-1:0] prod;
    div_req_t        div_req;
    div_rsp_t        div_rsp;
    scan_req_t       scan_req;
    scan_rsp_t       scan_rsp;

    logic [DW-1:0]  a_mag, b_mag, c_mag, hi_mag, lo_mag;
    logic           fits;
    logic           accept;
    logic [SHW-1:0] left;
    logic [DW-1:0]  q_scaled;

    smd_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    smd_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .rsp   (scan_rsp)
    );

    smd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign busy     = (state_reg != ST_IDLE) && (state_reg != ST_DONE);
    assign done     = (state_reg == ST_DONE);
    assign quotient = res_reg;
    assign accept   = start && !busy;

    assign a_mag  = mag32(a_reg);
    assign b_mag  = mag32(b_reg);
    assign c_mag  = mag32(c_reg);
    assign hi_mag = (a_mag > b_mag) ? a_mag : b_mag;
    assign lo_mag = (a_mag > b_mag) ? b_mag : a_mag;
    // full product fits in 32 bits when its top bits are all sign copies
    assign fits   = (&prod[2*DW-1:DW-1]) || !(|prod[2*DW-1:DW-1]);
    assign left   = scan_rsp.lz - SHW'(1);
    assign q_scaled = prod[DW-1:0] >> shift_reg;

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        shift_next = shift_reg;
        neg_next   = neg_reg;
        fast_next  = fast_reg;
        res_next   = res_reg;

        mul_req.load = 1'b0;
        mul_req.op_x = {factor_a[DW-1], factor_a};
        mul_req.op_y = {factor_b[DW-1], factor_b};

        div_req.start    = 1'b0;
        div_req.dividend = mag32(prod[DW-1:0]);
        div_req.divisor  = c_mag;

        scan_req.start  = 1'b0;
        scan_req.hi_mag = hi_mag;
        scan_req.lo_mag = lo_mag;
        scan_req.limit  = c_mag;

        case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                state_next = ST_IDLE;
                if (accept)
                begin
                    a_next       = factor_a;
                    b_next       = factor_b;
                    c_next       = divisor;
                    mul_req.load = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if ((a_reg == '0) || (b_reg == '0))
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else if (fits && (c_reg != '0))
                begin
                    fast_next     = 1'b1;
                    neg_next      = prod[DW-1] ^ c_reg[DW-1];
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    fast_next = 1'b0;
                    neg_next  = a_reg[DW-1] ^ b_reg[DW-1] ^ c_reg[DW-1];
                    hi_next   = hi_mag;
                    lo_next   = lo_mag;
                    if ((c_reg == '0) || hi_mag[DW-1])
                    begin
                        res_next   = apply_sign(SAT_MAG,
                                                a_reg[DW-1] ^ b_reg[DW-1] ^ c_reg[DW-1]);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        scan_req.start = 1'b1;
                        state_next     = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (scan_rsp.done)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (scan_rsp.right > left)
                begin
                    res_next   = apply_sign(SAT_MAG, neg_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    shift_next       = left - scan_rsp.right;
                    div_req.start    = 1'b1;
                    div_req.dividend = hi_reg << (left - scan_rsp.right);
                    state_next       = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = fast_reg ? ST_FIN : ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                mul_req.load = 1'b1;
                mul_req.op_x = {1'b0, div_rsp.quo};
                mul_req.op_y = {1'b0, lo_reg};
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                if (fast_reg)
                begin
                    // positive 2^31 only arises from -2^31 over -1: clamp
                    if (!neg_reg && div_rsp.quo[DW-1])
                    begin
                        res_next = SAT_MAG;
                    end
                    else
                    begin
                        res_next = apply_sign(div_rsp.quo, neg_reg);
                    end
                end
                else
                begin
                    res_next = apply_sign(q_scaled, neg_reg);
                end
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        shift_reg <= shift_next;
        neg_reg   <= neg_next;
        fast_reg  <= fast_next;
        res_reg   <= res_next;
    end

endmodule

// File: hw/rtl/smd_checker.sv
`include "scaled_multiply_divide_unit_assert.svh"

module smd_checker
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic [smd_pkg::DW-1:0]  factor_a,
    input logic [smd_pkg::DW-1:0]  factor_b,
    input logic [smd_pkg::DW-1:0]  quotient
);
    import smd_pkg::*;

    logic accept;
    logic zero_in;

    assign accept  = start && !busy;
    assign zero_in = (factor_a == '0) || (factor_b == '0);

    `SMD_ASSERT_NEXT(a_accept_busy, accept, busy && !done)
    `SMD_ASSERT_NEXT(a_done_single, done, !done)
    `SMD_ASSERT_NOW(a_busy_ends_in_result, $fell(busy), done)
    `SMD_ASSERT_NOW(a_zero_gives_zero, $past(accept && zero_in, 2), done && (quotient == '0))

endmodule

bind scaled_multiply_divide_unit smd_checker u_smd_checker (.*);

// File: dv/scaled_multiply_divide_unit_tb.sv
`timescale 1ns / 1ps

module scaled_multiply_divide_unit_tb;

    import smd_pkg::*;

    // No accepted beat on either side for this many cycles ends the run. The slowest item
    // takes the scaled path; sender gaps at 70 percent idling rarely come near the limit.
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 50;

    localparam logic [DW-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [DW-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] MINUS_1 = 32'hFFFF_FFFF;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [DW-1:0] factor_a;
    logic [DW-1:0] factor_b;
    logic [DW-1:0] divisor;
    logic          done;
    logic [DW-1:0] quotient;

    logic [DW-1:0] expected_quotients[$];
    logic [DW-1:0] oldest_quotient;
    int unsigned   stalled_cycles;
    int unsigned   error_count;

    scaled_multiply_divide_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .factor_a (factor_a),
        .factor_b (factor_b),
        .divisor  (divisor),
        .done     (done),
        .quotient (quotient)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // a*b/c with the exact-product shortcut and the pre-shifted magnitude path
    function automatic logic [DW-1:0] predict_quotient(logic [DW-1:0] fa, logic [DW-1:0] fb,
                                                        logic [DW-1:0] fc);
        longint      sa;
        longint      sb;
        longint      sc;
        longint      prod;
        longint      ratio;
        logic [DW-1:0] prod32;
        logic [DW-1:0] ma;
        logic [DW-1:0] mb;
        logic [DW-1:0] mc;
        logic [DW-1:0] big;
        logic [DW-1:0] lesser;
        logic [DW-1:0] q;
        logic [DW-1:0] sat;
        logic          neg;
        int unsigned   lz;
        int unsigned   left;
        int unsigned   right;
        int unsigned   shift;
        sa = longint'($signed(fa));
        sb = longint'($signed(fb));
        sc = longint'($signed(fc));
        if (sa == 0 || sb == 0)
        begin
            return '0;
        end
        prod32 = fa * fb;
        prod = longint'($signed(prod32));
        if (prod / sb == sa && sc != 0)
        begin
            ratio = prod / sc;
            // only INT_MIN / -1 lands here
            if (ratio > 64'sd2147483647)
            begin
                return SAT_MAG;
            end
            return ratio[31:0];
        end
        neg = fa[31] ^ fb[31] ^ fc[31];
        sat = neg ? (32'd0 - SAT_MAG) : SAT_MAG;
        ma = fa[31] ? (32'd0 - fa) : fa;
        mb = fb[31] ? (32'd0 - fb) : fb;
        mc = fc[31] ? (32'd0 - fc) : fc;
        if (mc == '0)
        begin
            return sat;
        end
        big = (ma > mb) ? ma : mb;
        lesser = (ma > mb) ? mb : ma;
        if (big[31])
        begin
            return sat;
        end
        lz = 0;
        while (lz < 32 && !big[31 - lz])
        begin
            lz++;
        end
        left = lz - 1;
        right = 0;
        while (right < 32 && (lesser >> right) > mc)
        begin
            right++;
        end
        if (right > left)
        begin
            return sat;
        end
        shift = left - right;
        q = (big << shift) / mc;
        q = q * lesser;
        q = q >> shift;
        return neg ? (32'd0 - q) : q;
    endfunction

    function automatic logic [DW-1:0] random_operand();
        logic [DW-1:0] mag;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return MINUS_1;
                    3:       return INT_MIN;
                    default: return INT_MAX;
                endcase
            end
            1, 2:
            begin
                return $urandom;
            end
            default:
            begin
                // random bit length keeps most items off the saturation rail
                mag = $urandom >> $urandom_range(31, 1);
                return $urandom_range(1) ? (32'd0 - mag) : mag;
            end
        endcase
    endfunction

    // Check results first so a same-edge accept never pairs with its own beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_quotients.size() == 0)
                begin
                    $display("%0t unexpected quotient: expected none, actual %h", $time, quotient);
                    error_count++;
                end
                else
                begin
                    oldest_quotient = expected_quotients.pop_front();
                    if (quotient !== oldest_quotient)
                    begin
                        $display("%0t quotient mismatch: expected %h, actual %h",
                                 $time, oldest_quotient, quotient);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_quotients.push_back(predict_quotient(factor_a, factor_b, divisor));
            end
            if ((start && !busy) || done)
            begin
                stalled_cycles = 0;
            end
            else
            begin
                stalled_cycles++;
            end
        end
    end

    initial
    begin : watchdog
        while (stalled_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("%0t no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("[scaled_multiply_divide_unit] ERROR");
        $finish;
    end

    // Hold the beat until taken, then idle the sender with random noise on the operands.
    task automatic send_beat(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c,
                             int unsigned idle_pct);
        @(negedge clk);
        start <= 1'b1;
        factor_a <= a;
        factor_b <= b;
        divisor <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            factor_a <= $urandom;
            factor_b <= $urandom;
            divisor <= $urandom;
        end
    endtask

    task automatic wait_drained();
        while (expected_quotients.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_random_beats(int unsigned count, int unsigned idle_pct);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_beat(random_operand(), random_operand(), random_operand(), idle_pct);
        end
    endtask

    task automatic test_directed_corners();
        send_beat('0, INT_MAX, 32'd5, 29);
        send_beat(32'd123, '0, '0, 29);
        send_beat(32'd7, 32'd9, '0, 29);
        send_beat(32'hFFFF_FFF9, 32'd9, '0, 29);
        send_beat(32'd6, 32'd7, 32'd4, 29);
        send_beat(32'hFFFF_FFFA, 32'd7, 32'd4, 29);
        send_beat(32'd6, 32'd7, 32'hFFFF_FFFC, 29);
        send_beat(INT_MAX, INT_MAX, 32'd1, 29);
        send_beat(INT_MAX, INT_MAX, INT_MAX, 29);
        send_beat(INT_MIN, 32'd3, 32'd2, 29);
        send_beat(32'd3, INT_MIN, 32'd2, 29);
        send_beat(INT_MIN, INT_MIN, 32'd1, 29);
        // INT_MIN times a b of -1 overflows 32 bits and must take the slow path
        send_beat(INT_MIN, MINUS_1, 32'd1, 29);
        send_beat(INT_MIN, 32'd1, MINUS_1, 29);
        send_beat(32'hC000_0000, 32'd2, MINUS_1, 29);
        send_beat(32'd100000, 32'd100000, 32'd7, 29);
        send_beat(32'd100000, 32'hFFFE_7960, 32'd7, 29);
        send_beat(32'd100000, 32'd100000, INT_MIN, 29);
        send_beat(32'd5, 32'd6, INT_MIN, 29);
        send_beat(32'h0100_0000, 32'h0100_0000, 32'd3, 29);
        send_beat(INT_MAX, 32'd2, 32'd1, 29);
        send_beat(MINUS_1, MINUS_1, MINUS_1, 29);
        send_beat(32'hAAAA_AAAA, 32'h5555_5555, 32'h5A5A_5A5A, 29);
    endtask

    task automatic test_random_sparse_sender();
        run_random_beats(176, 29);
    endtask

    task automatic test_random_heavy_idle();
        run_random_beats(176, 70);
    endtask

    task automatic test_random_back_to_back();
        run_random_beats(176, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        factor_a = '0;
        factor_b = '0;
        divisor = '0;
        stalled_cycles = 0;
        error_count = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_random_sparse_sender();
        @(negedge clk);
        start <= 1'b0;
        // drain fully before the next phase
        wait_drained();
        test_random_heavy_idle();
        @(negedge clk);
        start <= 1'b0;
        wait_drained();
        test_random_back_to_back();
        @(negedge clk);
        start <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("[scaled_multiply_divide_unit] OK");
        end
        else
        begin
            $display("[scaled_multiply_divide_unit] ERROR");
        end
        $finish;
    end

endmodule
